// ===== rtl/pnfc_pkg.sv =====
// Package for the pitch/frequency converter: step tables, word layouts and helper functions.
// Used by every module of the block; depends on nothing.
`default_nettype none
package pnfc_pkg;

  localparam int unsigned FreqW  = 24;
  localparam int unsigned InW    = 32;
  localparam int unsigned PitchW = 17;
  localparam int unsigned CoefW  = 17;
  localparam int unsigned NumW   = InW + 15;
  localparam int unsigned CntW   = $clog2(NumW + 1);
  localparam int unsigned AddrW  = 3;

  localparam logic [1:0] TabOct   = 2'd0;
  localparam logic [1:0] TabSemi  = 2'd1;
  localparam logic [1:0] TabFine  = 2'd2;
  localparam logic [1:0] TabXfine = 2'd3;

  localparam logic       OpToFreq  = 1'b0;
  localparam logic       OpToPitch = 1'b1;

  localparam logic [AddrW-1:0] RegBaseSelect = 3'd0;

  localparam logic [FreqW-1:0] Oct8363 [16] = '{
    24'd13594045, 24'd5394801, 24'd2140928, 24'd849628, 24'd337175, 24'd133808,
    24'd53102, 24'd21073, 24'd8363, 24'd3319, 24'd1317, 24'd523, 24'd207, 24'd82,
    24'd33, 24'd13};
  localparam logic [FreqW-1:0] Oct6848 [16] = '{
    24'd11131415, 24'd4417505, 24'd1753088, 24'd695713, 24'd276094, 24'd109568,
    24'd43482, 24'd17256, 24'd6848, 24'd2718, 24'd1078, 24'd428, 24'd170, 24'd67,
    24'd27, 24'd11};
  localparam logic [15:0] SemiSteps [16] = '{
    16'd32768, 16'd30929, 16'd29193, 16'd27554, 16'd26008, 16'd24548, 16'd23170,
    16'd21870, 16'd20643, 16'd19484, 16'd18390, 16'd17358, 16'd16384, 16'd15464,
    16'd14596, 16'd13777};
  localparam logic [15:0] FineSteps [16] = '{
    16'd32768, 16'd32650, 16'd32532, 16'd32415, 16'd32298, 16'd32182, 16'd32066,
    16'd31950, 16'd31835, 16'd31720, 16'd31606, 16'd31492, 16'd31379, 16'd31266,
    16'd31153, 16'd31041};
  localparam logic [15:0] XfineSteps [16] = '{
    16'd32768, 16'd32761, 16'd32753, 16'd32746, 16'd32738, 16'd32731, 16'd32724,
    16'd32716, 16'd32709, 16'd32702, 16'd32694, 16'd32687, 16'd32679, 16'd32672,
    16'd32665, 16'd32657};

  typedef struct packed {
    logic             start;
    logic [InW-1:0]   dividend;
    logic [FreqW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic [InW-1:0] quotient;
  } div_stat_t;

  function automatic logic [FreqW-1:0] tab_entry(input logic [1:0] sel, input logic base,
                                                 input logic [3:0] idx);
    logic [FreqW-1:0] e;
    unique case (sel)
      TabOct:   e = base ? Oct6848[idx] : Oct8363[idx];
      TabSemi:  e = {8'd0, SemiSteps[idx]};
      TabFine:  e = {8'd0, FineSteps[idx]};
      default:  e = {8'd0, XfineSteps[idx]};
    endcase
    return e;
  endfunction

  // First index whose following entry lies below f; the last index when none does.
  function automatic logic [3:0] pick_index(input logic [1:0] sel, input logic base,
                                            input logic [InW-1:0] f);
    logic [3:0] k;
    k = 4'd15;
    for (int i = 14; i >= 0; i--) begin
      if ({8'd0, tab_entry(sel, base, 4'(i + 1))} < f) begin
        k = 4'(i);
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pnfc_mul.sv =====
// Multiply-and-shift accumulator: the frequency is scaled by one step coefficient per cycle while step_i is high.
// Depends on pnfc_pkg.
`default_nettype none
module pnfc_mul import pnfc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic [FreqW-1:0] init_i,
  input  wire logic             step_i,
  input  wire logic [CoefW-1:0] coef_i,
  output logic      [FreqW-1:0] acc_o
);

  logic [FreqW-1:0]       acc_q;
  logic [FreqW-1:0]       acc_d;
  logic [FreqW+CoefW-1:0] prod;

  // The coefficient never exceeds 65536, so the shifted product fits the accumulator.
  assign prod = (FreqW + CoefW)'(acc_q) * (FreqW + CoefW)'(coef_i);

  always_comb begin
    acc_d = acc_q;
    if (load_i) begin
      acc_d = init_i;
    end else if (step_i) begin
      acc_d = prod[FreqW+15:16];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// ===== rtl/pnfc_div.sv =====
// Restoring divider, one quotient bit per cycle: (dividend * 32768) / divisor, low 32 bits kept.
// Depends on pnfc_pkg.
`default_nettype none
module pnfc_div import pnfc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_stat_t     stat_o
);

  logic             busy_q, busy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NumW-1:0]  num_q, num_d;
  logic [FreqW-1:0] rem_q, rem_d;
  logic [FreqW-1:0] dvs_q, dvs_d;
  logic [InW-1:0]   quo_q, quo_d;
  logic [FreqW:0]   trial;
  logic [FreqW:0]   diff;
  logic             ge;

  assign trial = {rem_q, num_q[NumW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      num_d  = {req_i.dividend, 15'd0};
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      rem_d = ge ? diff[FreqW-1:0] : trial[FreqW-1:0];
      quo_d = {quo_q[InW-2:0], ge};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/pitch_note_frequency_converter_unit.sv =====
// Pitch to frequency: three multiply steps, then the output register.
// Frequency to pitch: a table search per table, each but the last followed by a 47-step divide.
// One word is in work at a time; the input is ready again once the result is registered,
// and a stalled output holds the unit in its finish state until the result can be registered.
// Reset clears the sequencer, the output valid and base_select (8363 Hz table).
// Depends on pnfc_pkg, pnfc_mul and pnfc_div.
`default_nettype none
module pitch_note_frequency_converter_unit import pnfc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [47:0]       s_axis_tdata_i,   // pitch_in [15:0], freq_in [47:16]
  input  wire logic              s_axis_tuser_i,   // opcode
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [47:0]       m_axis_tdata_o,   // freq_out [23:0], pitch_out [40:24]
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StSrch,
    StDiv,
    StFinish
  } state_e;

  state_e           state_q;
  logic [1:0]       step_q;
  logic             opc_q;
  logic [15:0]      kvec_q;
  logic [InW-1:0]   f_q;
  logic             base_q;
  logic             m_valid_q;
  logic [47:0]      m_data_q;

  logic             accept;
  logic [15:0]      neg_pitch;
  logic [3:0]       oct_idx;
  logic [3:0]       nib;
  logic [FreqW-1:0] coef_ent;
  logic [CoefW-1:0] coef;
  logic [3:0]       pick;
  logic [FreqW-1:0] acc;
  logic             mul_load;
  logic             mul_step;
  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [PitchW-1:0] pitch_res;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == RegBaseSelect) ? {31'd0, base_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == RegBaseSelect) begin
      base_q <= pwdata[0];
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign neg_pitch       = 16'd0 - s_axis_tdata_i[15:0];
  assign oct_idx         = neg_pitch[15:12] ^ 4'h8;

  always_comb begin
    unique case (step_q)
      2'd0:    nib = kvec_q[11:8];
      2'd1:    nib = kvec_q[7:4];
      default: nib = kvec_q[3:0];
    endcase
  end

  assign coef_ent = tab_entry(step_q + 2'd1, base_q, nib);
  assign coef     = {coef_ent[15:0], 1'b0};
  assign pick     = pick_index(step_q, base_q, f_q);

  assign mul_load = accept && (s_axis_tuser_i == OpToFreq);
  assign mul_step = (state_q == StMul);

  pnfc_mul u_mul (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .init_i (tab_entry(TabOct, base_q, oct_idx)),
    .step_i (mul_step),
    .coef_i (coef),
    .acc_o  (acc)
  );

  assign div_req.start    = (state_q == StSrch) && (step_q != TabXfine);
  assign div_req.dividend = f_q;
  assign div_req.divisor  = tab_entry(step_q, base_q, pick);

  pnfc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat)
  );

  // The four indices form u; the pitch is 32768 - u.
  assign pitch_res = PitchW'(32768) - {1'b0, kvec_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      opc_q     <= OpToFreq;
      kvec_q    <= '0;
      f_q       <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i && state_q != StFinish) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            opc_q  <= s_axis_tuser_i;
            step_q <= '0;
            f_q    <= s_axis_tdata_i[47:16];
            if (s_axis_tuser_i == OpToFreq) begin
              kvec_q  <= neg_pitch;
              state_q <= StMul;
            end else begin
              state_q <= StSrch;
            end
          end
        end
        StMul: begin
          step_q <= step_q + 2'd1;
          if (step_q == 2'd2) begin
            state_q <= StFinish;
          end
        end
        StSrch: begin
          unique case (step_q)
            TabOct:  kvec_q[15:12] <= pick;
            TabSemi: kvec_q[11:8]  <= pick;
            TabFine: kvec_q[7:4]   <= pick;
            default: kvec_q[3:0]   <= pick;
          endcase
          state_q <= (step_q == TabXfine) ? StFinish : StDiv;
        end
        StDiv: begin
          if (!div_stat.busy) begin
            f_q     <= div_stat.quotient;
            step_q  <= step_q + 2'd1;
            state_q <= StSrch;
          end
        end
        StFinish: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            if (opc_q == OpToFreq) begin
              m_data_q <= {7'd0, {PitchW{1'b0}}, acc};
            end else begin
              m_data_q <= {7'd0, pitch_res, {FreqW{1'b0}}};
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule
`default_nettype wire
